[src/vertex_index_compactor_top_macros.svh]
// ----------------------------------------------------------------------------
// Vertex index compactor assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_INDEX_COMPACTOR_TOP_MACROS_SVH
`define VERTEX_INDEX_COMPACTOR_TOP_MACROS_SVH

// same-cycle implication
`define VIC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/vic_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex index compactor package
// Widths, result kinds, FSM encoding and field/index conversion helpers.
// ----------------------------------------------------------------------------
package vic_pkg;

    localparam int IDX_BITS   = 16;                // map address width
    localparam int MAP_DEPTH  = 1 << IDX_BITS;
    localparam int ENTRY_BITS = IDX_BITS + 1;      // valid + compact index
    localparam int FIELD_BITS = 16;                // vertex index port width
    localparam int ID_BITS    = 32;

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [IDX_BITS:0]     t_count;
    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [1:0]            t_corner;

    localparam logic    KIND_VERTEX = 1'b0;
    localparam logic    KIND_TRI    = 1'b1;
    localparam t_corner CORNER_A    = 2'd0;
    localparam t_corner CORNER_C    = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOKUP = 5'b00100,
        S_CHECK  = 5'b01000,
        S_TRI    = 5'b10000
    } t_state;

    // low IDX_BITS of a port index (zero-extended when the map is wider)
    function automatic t_idx key_from_field(input t_field v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDX_BITS-1:0];
    endfunction

    // map index back to a port-width field
    function automatic t_field field_from_idx(input t_idx v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

[src/vertex_index_compactor_top.sv]
// ----------------------------------------------------------------------------
// Vertex index compactor
// Renumbers mesh vertices compactly, one triangle per transfer.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------
//  in      | i_in_valid / o_in_stall  | tri_id, old_a, old_b, old_c
//  out     | o_out_valid / i_out_stall| kind, old_vertex, new_vertex, tri_uid,
//          |                          | new_a, new_b, new_c, last
//
//  Per triangle: accept in idle, then per corner a map read and a check/insert,
//  then the triangle result.
//  Pace is set by the single map RAM: per corner a read, then a write on a miss.
//  After reset a clearing pass writes every map entry, with o_in_stall high
//  throughout.
//  An output stall holds the sequencer in the check or triangle state.
// ----------------------------------------------------------------------------
`include "vertex_index_compactor_top_macros.svh"

module vertex_index_compactor_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [vic_pkg::ID_BITS-1:0]  i_tri_id,
    input  vic_pkg::t_field              i_old_a,
    input  vic_pkg::t_field              i_old_b,
    input  vic_pkg::t_field              i_old_c,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_kind,
    output vic_pkg::t_field              o_old_vertex,
    output vic_pkg::t_field              o_new_vertex,
    output logic [vic_pkg::ID_BITS-1:0]  o_tri_uid,
    output vic_pkg::t_field              o_new_a,
    output vic_pkg::t_field              o_new_b,
    output vic_pkg::t_field              o_new_c,
    output logic                         o_last
);

    vic_pkg::t_state                r_state;
    vic_pkg::t_idx                  r_clr_addr;
    vic_pkg::t_count                r_next_index;
    vic_pkg::t_corner               r_corner;
    logic [vic_pkg::ID_BITS-1:0]    r_tri_id;
    vic_pkg::t_idx                  r_key [3];
    vic_pkg::t_idx                  r_new [3];

    logic                           r_out_valid;
    logic                           r_out_kind;
    vic_pkg::t_field                r_out_old_vertex;
    vic_pkg::t_field                r_out_new_vertex;
    logic [vic_pkg::ID_BITS-1:0]    r_out_tri_uid;
    vic_pkg::t_field                r_out_new_a;
    vic_pkg::t_field                r_out_new_b;
    vic_pkg::t_field                r_out_new_c;
    logic                           r_out_last;

    logic                           w_ram_we;
    vic_pkg::t_idx                  w_ram_waddr;
    vic_pkg::t_entry                w_ram_wdata;
    logic                           w_ram_re;
    vic_pkg::t_entry                w_ram_rdata;

    vic_pkg::t_idx                  w_key;
    vic_pkg::t_idx                  w_fresh;
    logic                           w_hit;
    vic_pkg::t_idx                  w_map_idx;
    logic                           w_out_free;
    logic                           w_in_xfer;
    logic                           w_out_xfer;
    logic                           w_out_load;

    assign w_key      = r_key[r_corner];
    assign w_fresh    = r_next_index[vic_pkg::IDX_BITS-1:0];
    assign w_hit      = w_ram_rdata[vic_pkg::IDX_BITS];
    assign w_map_idx  = w_ram_rdata[vic_pkg::IDX_BITS-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    // a new result enters the output register this cycle
    assign w_out_load = ((r_state == vic_pkg::S_CHECK) && !w_hit && w_out_free) ||
                        ((r_state == vic_pkg::S_TRI) && w_out_free);

    // map RAM control
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_key;
        w_ram_wdata = {1'b1, w_fresh};
        w_ram_re    = 1'b0;
        case (r_state)
            vic_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            vic_pkg::S_LOOKUP: begin
                w_ram_re = 1'b1;
            end
            vic_pkg::S_CHECK: begin
                w_ram_we = !w_hit && w_out_free;
            end
            default: begin
            end
        endcase
    end

    vic_ram #(
        .WIDTH (vic_pkg::ENTRY_BITS),
        .DEPTH (vic_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_key),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vic_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_next_index <= '0;
            r_corner     <= vic_pkg::CORNER_A;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_xfer && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                vic_pkg::S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= vic_pkg::S_IDLE;
                    end
                end
                vic_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_tri_id <= i_tri_id;
                        r_key[0] <= vic_pkg::key_from_field(i_old_a);
                        r_key[1] <= vic_pkg::key_from_field(i_old_b);
                        r_key[2] <= vic_pkg::key_from_field(i_old_c);
                        r_corner <= vic_pkg::CORNER_A;
                        r_state  <= vic_pkg::S_LOOKUP;
                    end
                end
                vic_pkg::S_LOOKUP: begin
                    r_state <= vic_pkg::S_CHECK;
                end
                vic_pkg::S_CHECK: begin
                    // read data stays put while waiting on the output slot
                    if (w_hit || w_out_free) begin
                        if (w_hit) begin
                            r_new[r_corner] <= w_map_idx;
                        end else begin
                            r_new[r_corner]  <= w_fresh;
                            r_next_index     <= r_next_index + 1'b1;
                            r_out_valid      <= 1'b1;
                            r_out_kind       <= vic_pkg::KIND_VERTEX;
                            r_out_old_vertex <= vic_pkg::field_from_idx(w_key);
                            r_out_new_vertex <= vic_pkg::field_from_idx(w_fresh);
                            r_out_tri_uid    <= '0;
                            r_out_new_a      <= '0;
                            r_out_new_b      <= '0;
                            r_out_new_c      <= '0;
                            r_out_last       <= 1'b0;
                        end
                        if (r_corner == vic_pkg::CORNER_C) begin
                            r_state <= vic_pkg::S_TRI;
                        end else begin
                            r_corner <= r_corner + 1'b1;
                            r_state  <= vic_pkg::S_LOOKUP;
                        end
                    end
                end
                vic_pkg::S_TRI: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_kind       <= vic_pkg::KIND_TRI;
                        r_out_old_vertex <= '0;
                        r_out_new_vertex <= '0;
                        r_out_tri_uid    <= r_tri_id;
                        r_out_new_a      <= vic_pkg::field_from_idx(r_new[0]);
                        r_out_new_b      <= vic_pkg::field_from_idx(r_new[1]);
                        r_out_new_c      <= vic_pkg::field_from_idx(r_new[2]);
                        r_out_last       <= 1'b1;
                        r_state          <= vic_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= vic_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != vic_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_old_vertex = r_out_old_vertex;
    assign o_new_vertex = r_out_new_vertex;
    assign o_tri_uid    = r_out_tri_uid;
    assign o_new_a      = r_out_new_a;
    assign o_new_b      = r_out_new_b;
    assign o_new_c      = r_out_new_c;
    assign o_last       = r_out_last;

    // map is only written by the clearing pass or an insert on a miss
    `VIC_ASSERT_SAME(a_map_write_src, w_ram_we,
        (r_state == vic_pkg::S_CLEAR) || ((r_state == vic_pkg::S_CHECK) && !w_hit),
        "map written outside clear or insert")
    // every insert advances the compact index count by one
    `VIC_ASSERT_NEXT(a_count_on_insert, w_ram_we && (r_state == vic_pkg::S_CHECK),
        r_next_index == $past(r_next_index) + 1'b1,
        "compact index count did not advance on insert")
    // an accepted triangle starts at corner a with a map read
    `VIC_ASSERT_NEXT(a_accept_start, w_in_xfer,
        (r_state == vic_pkg::S_LOOKUP) && (r_corner == vic_pkg::CORNER_A),
        "accepted triangle did not start a lookup at corner a")
    // triangle results and only those end a run
    `VIC_ASSERT_SAME(a_last_is_tri, r_out_valid, r_out_kind == r_out_last,
        "last flag disagrees with result kind")

endmodule

[src/vic_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
module vic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[bench/vertex_index_compactor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex index compactor checker
// Watches both channels, keeps its own original-to-compact index map and
// compares every output transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module vertex_index_compactor_checker
    import vic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [ID_BITS-1:0] i_tri_id,
    input  t_field             i_old_a,
    input  t_field             i_old_b,
    input  t_field             i_old_c,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_kind,
    input  t_field             i_old_vertex,
    input  t_field             i_new_vertex,
    input  logic [ID_BITS-1:0] i_tri_uid,
    input  t_field             i_new_a,
    input  t_field             i_new_b,
    input  t_field             i_new_c,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               kind;
        t_field             old_vertex;
        t_field             new_vertex;
        logic [ID_BITS-1:0] tri_uid;
        t_field             new_a;
        t_field             new_b;
        t_field             new_c;
        logic               last;
    } t_result;

    t_entry  compact_map [MAP_DEPTH];
    t_count  assigned_count = '0;
    t_result awaited_results [$];
    int      fail_count = 0;
    bit      map_clean = 1'b0;

    task automatic report_mismatch(input string what, input logic [ID_BITS-1:0] got,
                                   input logic [ID_BITS-1:0] want);
        // keep the log bounded when the block is badly broken
        if (fail_count < 100)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [ID_BITS-1:0] got,
                               input logic [ID_BITS-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // map one corner; a first sighting takes the next compact index
    function automatic t_field compact_index_of(input t_field old_idx);
        t_idx    key;
        t_idx    fresh;
        t_result vtx;
        key = t_idx'(old_idx);
        if (compact_map[key][IDX_BITS])
            return t_field'(compact_map[key][IDX_BITS-1:0]);
        fresh            = t_idx'(assigned_count);
        compact_map[key] = {1'b1, fresh};
        assigned_count   = assigned_count + 1'b1;
        vtx              = '0;
        vtx.kind         = KIND_VERTEX;
        vtx.old_vertex   = t_field'(key);
        vtx.new_vertex   = t_field'(fresh);
        awaited_results.push_back(vtx);
        return t_field'(fresh);
    endfunction

    function automatic void renumber_triangle(input logic [ID_BITS-1:0] id,
                                              input t_field a, input t_field b,
                                              input t_field c);
        t_result tri_res;
        tri_res         = '0;
        tri_res.kind    = KIND_TRI;
        tri_res.tri_uid = id;
        tri_res.new_a   = compact_index_of(a);
        tri_res.new_b   = compact_index_of(b);
        tri_res.new_c   = compact_index_of(c);
        tri_res.last    = 1'b1;
        awaited_results.push_back(tri_res);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            if (!map_clean) begin
                foreach (compact_map[i])
                    compact_map[i] = '0;
                map_clean = 1'b1;
            end
            assigned_count = '0;
            awaited_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                renumber_triangle(i_tri_id, i_old_a, i_old_b, i_old_c);
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result transfer (kind)",
                                    ID_BITS'(i_kind), 'x);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind",       ID_BITS'(i_kind),
                                ID_BITS'(want.kind));
                    check_field("old_vertex", ID_BITS'(i_old_vertex),
                                ID_BITS'(want.old_vertex));
                    check_field("new_vertex", ID_BITS'(i_new_vertex),
                                ID_BITS'(want.new_vertex));
                    check_field("tri_uid",    i_tri_uid, want.tri_uid);
                    check_field("new_a",      ID_BITS'(i_new_a),
                                ID_BITS'(want.new_a));
                    check_field("new_b",      ID_BITS'(i_new_b),
                                ID_BITS'(want.new_b));
                    check_field("new_c",      ID_BITS'(i_new_c),
                                ID_BITS'(want.new_c));
                    check_field("last",       ID_BITS'(i_last),
                                ID_BITS'(want.last));
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

[bench/vertex_index_compactor_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex index compactor testbench
// Directed corner triangles, then random triangles under several idle/stall
// mixes, two of them with a long output hold-off.
// ----------------------------------------------------------------------------
module vertex_index_compactor_top_test;
    import vic_pkg::*;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [ID_BITS-1:0] i_tri_id    = '0;
    t_field             i_old_a     = '0;
    t_field             i_old_b     = '0;
    t_field             i_old_c     = '0;
    logic               i_out_stall = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_kind;
    t_field             o_old_vertex;
    t_field             o_new_vertex;
    logic [ID_BITS-1:0] o_tri_uid;
    t_field             o_new_a;
    t_field             o_new_b;
    t_field             o_new_c;
    logic               o_last;

    int     fail_count;
    int     pending_count;
    int     idle_pct    = 0;
    int     stall_pct   = 0;
    int     hold_reqs   = 0;
    int     hold_served = 0;
    int     hold_left   = 0;
    t_field used_vertices [$];

    always #4 i_clk = ~i_clk;

    vertex_index_compactor_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_tri_id     (i_tri_id),
        .i_old_a      (i_old_a),
        .i_old_b      (i_old_b),
        .i_old_c      (i_old_c),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_old_vertex (o_old_vertex),
        .o_new_vertex (o_new_vertex),
        .o_tri_uid    (o_tri_uid),
        .o_new_a      (o_new_a),
        .o_new_b      (o_new_b),
        .o_new_c      (o_new_c),
        .o_last       (o_last)
    );

    vertex_index_compactor_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_tri_id     (i_tri_id),
        .i_old_a      (i_old_a),
        .i_old_b      (i_old_b),
        .i_old_c      (i_old_c),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_kind       (o_kind),
        .i_old_vertex (o_old_vertex),
        .i_new_vertex (o_new_vertex),
        .i_tri_uid    (o_tri_uid),
        .i_new_a      (o_new_a),
        .i_new_b      (o_new_b),
        .i_new_c      (o_new_c),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // output back-pressure; a hold-off request stalls for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_reqs != hold_served) begin
            hold_served = hold_reqs;
            hold_left   = 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_triangle(input logic [ID_BITS-1:0] id, input t_field a,
                                 input t_field b, input t_field c);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tri_id   <= id;
        i_old_a    <= a;
        i_old_b    <= b;
        i_old_c    <= c;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // mostly a small cluster and reused indices so hits and misses both occur
    function automatic t_field pick_vertex();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return t_field'($urandom_range(511));
        if (r < 70 && used_vertices.size() > 0)
            return used_vertices[$urandom_range(used_vertices.size() - 1)];
        if (r < 90)
            return t_field'($urandom_range(65535));
        if (r < 95)
            return t_field'(1) << $urandom_range(FIELD_BITS - 1);
        return r[0] ? '1 : '0;
    endfunction

    task automatic random_triangles(input int count);
        t_field a;
        t_field b;
        t_field c;
        int     r;
        repeat (count) begin
            a = pick_vertex();
            b = pick_vertex();
            c = pick_vertex();
            r = $urandom_range(99);
            // repeated corners
            if (r < 12) begin
                b = a;
            end else if (r < 20) begin
                c = a;
            end else if (r < 28) begin
                c = b;
            end else if (r < 32) begin
                b = a;
                c = a;
            end
            send_triangle($urandom, a, b, c);
            used_vertices.push_back(a);
            used_vertices.push_back(b);
            used_vertices.push_back(c);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and repeated corners
        send_triangle(32'h0000_0000, 16'd0,     16'd1,     16'd2);
        send_triangle(32'hFFFF_FFFF, 16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_triangle(32'h0000_0001, 16'd0,     16'd1,     16'd2);
        send_triangle(32'hAAAA_AAAA, 16'd7,     16'd7,     16'd8);
        send_triangle(32'h5555_5555, 16'd9,     16'd10,    16'd10);
        send_triangle(32'h8000_0000, 16'd11,    16'd12,    16'd11);
        send_triangle(32'h7FFF_FFFF, 16'd0,     16'd13,    16'hFFFF);
        send_triangle(32'h1234_5678, 16'h8000,  16'h7FFF,  16'h5555);
        send_triangle(32'h0F0F_F0F0, 16'hAAAA,  16'h5555,  16'hAAAA);
        send_triangle(32'hDEAD_0001, 16'h0100,  16'h0200,  16'h0300);
        send_triangle(32'hDEAD_0002, 16'h0300,  16'h0400,  16'h0100);
        send_triangle(32'hDEAD_0003, 16'h8000,  16'h8000,  16'h0001);

        // no idling, with a long output hold-off so the input backs up
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs = hold_reqs + 1;
        random_triangles(110);

        idle_pct  = 61;
        stall_pct = 0;
        random_triangles(105);

        idle_pct  = 0;
        stall_pct = 61;
        random_triangles(105);

        idle_pct  = 15;
        stall_pct = 15;
        hold_reqs = hold_reqs + 1;
        random_triangles(110);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/vic_pkg.sv
src/vic_ram.sv
src/vertex_index_compactor_top.sv
bench/vertex_index_compactor_checker.sv
bench/vertex_index_compactor_top_test.sv
